/* hdl/cm_pkg.sv */
// covariance matrix package: sizes, widths, state encoding, divider bundles
// and the lower-triangle index function; no dependencies
`timescale 1ns / 1ps
package cm_pkg;

  localparam int MAX_SAMPLES  = 256;
  localparam int MAX_FEATURES = 8;
  localparam int STORE_DEPTH  = MAX_SAMPLES * MAX_FEATURES;
  localparam int TRI_DEPTH    = (MAX_FEATURES * (MAX_FEATURES + 1)) / 2;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int LCNT_W = $clog2(STORE_DEPTH + 1);
  localparam int SCNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int FCNT_W = $clog2(MAX_FEATURES + 1);
  localparam int FIDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int TRI_W  = (TRI_DEPTH > 1) ? $clog2(TRI_DEPTH) : 1;

  localparam int SAMPLE_W = 16;
  localparam int MEAN_W   = 25;
  localparam int CEN_W    = 26;
  localparam int PROD_W   = 2 * CEN_W;
  localparam int SUM_W    = 58;
  localparam int COV_W    = 64;
  localparam int DCNT_W   = $clog2(SUM_W + 1);

  localparam logic [1:0] REG_SAMPLE_COUNT  = 2'd0;
  localparam logic [1:0] REG_FEATURE_COUNT = 2'd1;
  localparam logic [1:0] REG_NORMALIZE     = 2'd2;

  typedef enum logic [3:0] {
    S_LOAD,
    S_MEAN,
    S_MEAN_DIV,
    S_PAIR_MI,
    S_PAIR_MJ,
    S_SUM,
    S_SUM_DIV,
    S_OUT_RD,
    S_OUT_LD
  } cm_state_t;

  typedef struct packed {
    logic                     start;
    logic signed [SUM_W-1:0]  dividend;
    logic [SCNT_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [SUM_W-1:0]  quotient;
  } div_rsp_t;

  function automatic logic [TRI_W-1:0] tri_idx(input logic [FIDX_W-1:0] r,
                                               input logic [FIDX_W-1:0] c);
    int hi;
    int lo;
    hi = (r > c) ? int'(r) : int'(c);
    lo = (r > c) ? int'(c) : int'(r);
    return TRI_W'((hi * (hi + 1)) / 2 + lo);
  endfunction

endpackage

/* hdl/cm_sample_ram.sv */
// sample storage: one write port, two registered read ports
// depends on cm_pkg
`timescale 1ns / 1ps
module cm_sample_ram (
  input  logic                           clk,
  input  logic                           we,
  input  logic [cm_pkg::ADDR_W-1:0]      waddr,
  input  logic [cm_pkg::SAMPLE_W-1:0]    wdata,
  input  logic [cm_pkg::ADDR_W-1:0]      raddr_a,
  input  logic [cm_pkg::ADDR_W-1:0]      raddr_b,
  output logic [cm_pkg::SAMPLE_W-1:0]    rdata_a,
  output logic [cm_pkg::SAMPLE_W-1:0]    rdata_b
);
  import cm_pkg::*;

  logic [SAMPLE_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* hdl/cm_divider.sv */
// signed by unsigned restoring divider, one quotient bit per cycle,
// truncates toward zero; depends on cm_pkg
`timescale 1ns / 1ps
module cm_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  cm_pkg::div_req_t  req,
  output cm_pkg::div_rsp_t  rsp
);
  import cm_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              neg_r, neg_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [SCNT_W-1:0] div_r, div_nxt;
  logic [SCNT_W-1:0] rem_r, rem_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [SCNT_W:0]   rem_sh;
  logic [SCNT_W:0]   rem_sub;
  logic              ge;

  always_comb begin
    rem_sh   = {rem_r, quo_r[SUM_W-1]};
    ge       = rem_sh >= {1'b0, div_r};
    rem_sub  = rem_sh - {1'b0, div_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      neg_nxt  = req.dividend[SUM_W-1];
      cnt_nxt  = DCNT_W'(SUM_W);
      div_nxt  = req.divisor;
      rem_nxt  = '0;
      quo_nxt  = req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
    end else if (busy_r) begin
      quo_nxt = {quo_r[SUM_W-2:0], ge};
      rem_nxt = ge ? rem_sub[SCNT_W-1:0] : rem_sh[SCNT_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

/* hdl/covariance_matrix.sv */
// covariance matrix top: sequencer, mean and cross-product datapath, result memory
// after the last element: a mean per feature, then nf*(nf+1)/2 cross-product sums
// (one shared divider run per mean and per sum; a zero divisor skips it for the sums),
// then each entry is read from the result memory and sent out
// one element per cycle while loading; no element taken until the matrix is out
// synchronous active-low reset clears control and config; no memory clearing pass
`timescale 1ns / 1ps
module covariance_matrix (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [1:0]                      cfg_index,
  input  logic [8:0]                      cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [15:0]              in_sample_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [63:0]              out_cov_value,
  output logic [2:0]                      out_row_index,
  output logic [2:0]                      out_col_index,
  output logic                            out_divide_error,
  output logic                            out_last_entry
);
  import cm_pkg::*;

  logic [8:0] sc_r;
  logic [3:0] fc_r;
  logic       norm_r;

  logic [SCNT_W-1:0] ns;
  logic [FCNT_W-1:0] nf;
  logic [SCNT_W-1:0] dv;
  logic              dv_zero;
  logic [31:0]       total;
  logic [FIDX_W-1:0] last_f;

  cm_state_t state_r, state_nxt;
  logic [LCNT_W-1:0] load_cnt_r, load_cnt_nxt;
  logic [FIDX_W-1:0] i_r, i_nxt, j_r, j_nxt, r_r, r_nxt, c_r, c_nxt;
  logic [SCNT_W-1:0] k_r, k_nxt;
  logic [ADDR_W-1:0] base_i_r, base_i_nxt, base_j_r, base_j_nxt;
  logic [TRI_W-1:0]  tri_r, tri_nxt;
  logic              rv_r, rv_nxt, cv_r, cv_nxt, pv_r, pv_nxt;
  logic signed [CEN_W-1:0]  ca_r, ca_nxt, cb_r, cb_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [SUM_W-1:0]  acc_r, acc_nxt;
  logic signed [MEAN_W-1:0] mi_r, mi_nxt, mj_r, mj_nxt;
  logic signed [MEAN_W-1:0] means_r [MAX_FEATURES];
  logic signed [MEAN_W-1:0] mean_rd;
  logic [FIDX_W-1:0]        mean_ra;
  logic                     mean_we;

  logic                 mem_we, issue;
  logic [ADDR_W-1:0]    raddr_a, raddr_b;
  logic [SAMPLE_W-1:0]  rdata_a, rdata_b;

  logic                     res_we, res_re, pair_fin;
  logic [TRI_W-1:0]         res_raddr;
  logic signed [SUM_W-1:0]  res_wdata;
  logic signed [SUM_W-1:0]  res_mem [TRI_DEPTH];
  logic signed [SUM_W-1:0]  res_rdata_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic out_ld;
  logic out_valid_r, out_valid_nxt;
  logic signed [COV_W-1:0] cov_r;
  logic [FIDX_W-1:0] orow_r, ocol_r;
  logic err_r, last_r;

  // effective shape
  always_comb begin
    if (sc_r == '0) begin
      ns = SCNT_W'(1);
    end else if (32'(sc_r) > 32'(MAX_SAMPLES)) begin
      ns = SCNT_W'(MAX_SAMPLES);
    end else begin
      ns = SCNT_W'(sc_r);
    end
    if (fc_r == '0) begin
      nf = FCNT_W'(1);
    end else if (32'(fc_r) > 32'(MAX_FEATURES)) begin
      nf = FCNT_W'(MAX_FEATURES);
    end else begin
      nf = FCNT_W'(fc_r);
    end
    dv      = norm_r ? ns : ns - 1'b1;
    dv_zero = (dv == '0);
    total   = 32'(ns) * 32'(nf);
    last_f  = FIDX_W'(nf - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r   <= 9'd2;
      fc_r   <= 4'd1;
      norm_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SAMPLE_COUNT:  sc_r   <= cfg_wr_data;
        REG_FEATURE_COUNT: fc_r   <= cfg_wr_data[3:0];
        REG_NORMALIZE:     norm_r <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  assign mean_ra = (state_r == S_PAIR_MI) ? i_r : j_r;
  assign mean_rd = means_r[mean_ra];
  assign raddr_a = ADDR_W'(32'(base_i_r) + 32'(k_r));
  assign raddr_b = ADDR_W'(32'(base_j_r) + 32'(k_r));

  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    r_nxt        = r_r;
    c_nxt        = c_r;
    k_nxt        = k_r;
    base_i_nxt   = base_i_r;
    base_j_nxt   = base_j_r;
    tri_nxt      = tri_r;
    ca_nxt       = ca_r;
    cb_nxt       = cb_r;
    prod_nxt     = prod_r;
    acc_nxt      = acc_r;
    mi_nxt       = mi_r;
    mj_nxt       = mj_r;
    mean_we      = 1'b0;
    mem_we       = 1'b0;
    issue        = 1'b0;
    res_re       = 1'b0;
    res_raddr    = tri_idx(r_r, c_r);
    res_wdata    = '0;
    pair_fin     = 1'b0;
    res_we       = 1'b0;
    out_ld       = 1'b0;
    in_ready     = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = acc_r;
    div_req.divisor  = dv;

    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mem_we = 1'b1;
          if (32'(load_cnt_r) + 32'd1 == total) begin
            load_cnt_nxt = '0;
            i_nxt        = '0;
            k_nxt        = '0;
            base_i_nxt   = '0;
            acc_nxt      = '0;
            state_nxt    = S_MEAN;
          end else begin
            load_cnt_nxt = load_cnt_r + 1'b1;
          end
        end
      end
      S_MEAN: begin
        if (k_r != ns) begin
          issue = 1'b1;
          k_nxt = k_r + 1'b1;
        end
        if (rv_r) begin
          acc_nxt = acc_r + SUM_W'($signed(rdata_a));
        end
        if (k_r == ns && !rv_r) begin
          div_req.start    = 1'b1;
          div_req.dividend = acc_r <<< 8;
          div_req.divisor  = ns;
          state_nxt        = S_MEAN_DIV;
        end
      end
      S_MEAN_DIV: begin
        if (div_rsp.done) begin
          mean_we = 1'b1;
          if (i_r == last_f) begin
            i_nxt      = '0;
            j_nxt      = '0;
            base_i_nxt = '0;
            base_j_nxt = '0;
            tri_nxt    = '0;
            state_nxt  = S_PAIR_MI;
          end else begin
            i_nxt      = i_r + 1'b1;
            base_i_nxt = ADDR_W'(32'(base_i_r) + 32'(ns));
            k_nxt      = '0;
            acc_nxt    = '0;
            state_nxt  = S_MEAN;
          end
        end
      end
      S_PAIR_MI: begin
        mi_nxt    = mean_rd;
        state_nxt = S_PAIR_MJ;
      end
      S_PAIR_MJ: begin
        mj_nxt    = mean_rd;
        k_nxt     = '0;
        acc_nxt   = '0;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (k_r != ns) begin
          issue = 1'b1;
          k_nxt = k_r + 1'b1;
        end
        if (rv_r) begin
          ca_nxt = CEN_W'($signed({rdata_a, 8'h00})) - CEN_W'(mi_r);
          cb_nxt = CEN_W'($signed({rdata_b, 8'h00})) - CEN_W'(mj_r);
        end
        if (cv_r) begin
          prod_nxt = ca_r * cb_r;
        end
        if (pv_r) begin
          acc_nxt = acc_r + SUM_W'(prod_r);
        end
        if (k_r == ns && !rv_r && !cv_r && !pv_r) begin
          if (dv_zero) begin
            pair_fin = 1'b1;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = S_SUM_DIV;
          end
        end
      end
      S_SUM_DIV: begin
        if (div_rsp.done) begin
          res_wdata = div_rsp.quotient;
          pair_fin  = 1'b1;
        end
      end
      S_OUT_RD: begin
        res_re    = 1'b1;
        state_nxt = S_OUT_LD;
      end
      S_OUT_LD: begin
        if (!out_valid_r || out_ready) begin
          out_ld    = 1'b1;
          state_nxt = S_OUT_RD;
          if (c_r == last_f) begin
            c_nxt = '0;
            if (r_r == last_f) begin
              r_nxt     = '0;
              state_nxt = S_LOAD;
            end else begin
              r_nxt = r_r + 1'b1;
            end
          end else begin
            c_nxt = c_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase

    if (pair_fin) begin
      res_we  = 1'b1;
      tri_nxt = tri_r + 1'b1;
      if (j_r == i_r) begin
        if (i_r == last_f) begin
          r_nxt     = '0;
          c_nxt     = '0;
          state_nxt = S_OUT_RD;
        end else begin
          i_nxt      = i_r + 1'b1;
          j_nxt      = '0;
          base_i_nxt = ADDR_W'(32'(base_i_r) + 32'(ns));
          base_j_nxt = '0;
          state_nxt  = S_PAIR_MI;
        end
      end else begin
        j_nxt      = j_r + 1'b1;
        base_j_nxt = ADDR_W'(32'(base_j_r) + 32'(ns));
        state_nxt  = S_PAIR_MI;
      end
    end

    if (cfg_wr_en && (cfg_index == REG_SAMPLE_COUNT || cfg_index == REG_FEATURE_COUNT)) begin
      load_cnt_nxt = '0;
    end

    rv_nxt = issue;
    cv_nxt = rv_r && (state_r == S_SUM);
    pv_nxt = cv_r;

    out_valid_nxt = out_valid_r && !out_ready;
    if (out_ld) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      load_cnt_r  <= '0;
      rv_r        <= 1'b0;
      cv_r        <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      rv_r        <= rv_nxt;
      cv_r        <= cv_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    r_r      <= r_nxt;
    c_r      <= c_nxt;
    k_r      <= k_nxt;
    base_i_r <= base_i_nxt;
    base_j_r <= base_j_nxt;
    tri_r    <= tri_nxt;
    ca_r     <= ca_nxt;
    cb_r     <= cb_nxt;
    prod_r   <= prod_nxt;
    acc_r    <= acc_nxt;
    mi_r     <= mi_nxt;
    mj_r     <= mj_nxt;
    if (mean_we) begin
      means_r[i_r] <= div_rsp.quotient[MEAN_W-1:0];
    end
  end

  // lower-triangle result memory
  always_ff @(posedge clk) begin
    if (res_we) begin
      res_mem[tri_r] <= res_wdata;
    end
    if (res_re) begin
      res_rdata_r <= res_mem[res_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      cov_r  <= dv_zero ? '0 : COV_W'(res_rdata_r);
      orow_r <= r_r;
      ocol_r <= c_r;
      err_r  <= dv_zero;
      last_r <= (r_r == last_f) && (c_r == last_f);
    end
  end

  cm_sample_ram u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (load_cnt_r[ADDR_W-1:0]),
    .wdata   (in_sample_value),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  cm_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_valid        = out_valid_r;
  assign out_cov_value    = cov_r;
  assign out_row_index    = 3'(orow_r);
  assign out_col_index    = 3'(ocol_r);
  assign out_divide_error = err_r;
  assign out_last_entry   = last_r;

  a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_entry |-> out_row_index == out_col_index)
    else $error("last entry off the diagonal");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_error |-> out_cov_value == '0)
    else $error("divide error with nonzero value");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOAD |-> 32'(load_cnt_r) < total)
    else $error("load count past data set size");

endmodule

/* tb/covariance_matrix_tb.sv */
// covariance_matrix testbench: column-major data sets, shape and mode settings,
// results checked against a two-pass covariance predictor; depends on cm_pkg
`timescale 1ns / 1ps
module covariance_matrix_tb;
  import cm_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    longint   cov;
    bit [2:0] row;
    bit [2:0] col;
    bit       div_err;
    bit       last;
  } cov_entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_wr_data = '0;
  logic in_valid;
  logic in_ready;
  logic signed [15:0] in_sample_value;
  logic out_valid;
  logic out_ready;
  logic signed [63:0] out_cov_value;
  logic [2:0] out_row_index;
  logic [2:0] out_col_index;
  logic out_divide_error;
  logic out_last_entry;

  logic signed [15:0] sample_queue[$];
  cov_entry_t cov_expected[$];
  bit calm = 1'b0;
  int mismatches = 0;
  int item_total = 0;

  // predictor state
  logic [8:0] m_samples = 9'd2;
  logic [3:0] m_features = 4'd1;
  bit m_norm = 1'b0;
  shortint m_store[STORE_DEPTH];
  int m_load = 0;

  covariance_matrix i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample_value(in_sample_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_cov_value(out_cov_value),
    .out_row_index(out_row_index), .out_col_index(out_col_index),
    .out_divide_error(out_divide_error), .out_last_entry(out_last_entry)
  );

  always #2 clk = ~clk;

  function automatic int eff_samples();
    if (m_samples == 0) return 1;
    if (m_samples > MAX_SAMPLES) return MAX_SAMPLES;
    return int'(m_samples);
  endfunction

  function automatic int eff_features();
    if (m_features == 0) return 1;
    if (m_features > MAX_FEATURES) return MAX_FEATURES;
    return int'(m_features);
  endfunction

  function automatic void load_sample(shortint v);
    int ns;
    int nf;
    longint acc;
    longint a;
    longint b;
    longint divisor;
    longint means[MAX_FEATURES];
    longint sums[MAX_FEATURES][MAX_FEATURES];
    cov_entry_t e;
    ns = eff_samples();
    nf = eff_features();
    if (m_load >= ns * nf) m_load = 0;
    m_store[m_load] = v;
    m_load++;
    if (m_load < ns * nf) return;
    m_load = 0;
    for (int i = 0; i < nf; i++) begin
      acc = 0;
      for (int k = 0; k < ns; k++) acc += m_store[i * ns + k];
      means[i] = (acc * 256) / ns;
    end
    for (int i = 0; i < nf; i++) begin
      for (int j = 0; j <= i; j++) begin
        acc = 0;
        for (int k = 0; k < ns; k++) begin
          a = longint'(m_store[i * ns + k]) * 256 - means[i];
          b = longint'(m_store[j * ns + k]) * 256 - means[j];
          acc += a * b;
        end
        sums[i][j] = acc;
        sums[j][i] = acc;
      end
    end
    divisor = m_norm ? ns : ns - 1;
    for (int r = 0; r < nf; r++) begin
      for (int c = 0; c < nf; c++) begin
        e.div_err = (divisor == 0);
        e.cov = e.div_err ? 0 : sums[r][c] / divisor;
        e.row = r[2:0];
        e.col = c[2:0];
        e.last = (r == nf - 1) && (c == nf - 1);
        cov_expected.push_back(e);
      end
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_sample_value <= '0;
    end else if (!in_valid || in_ready) begin
      if (sample_queue.size() > 0 && (calm || $urandom_range(99) >= 36)) begin
        in_valid <= 1'b1;
        in_sample_value <= sample_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= calm || $urandom_range(99) >= 36;
  end

  // monitor
  always @(posedge clk) begin
    cov_entry_t e;
    if (rst_n && in_valid && in_ready) load_sample(in_sample_value);
    if (rst_n && out_valid && out_ready) begin
      if (cov_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: cov %0d row %0d col %0d",
                   out_cov_value, out_row_index, out_col_index);
      end else begin
        e = cov_expected.pop_front();
        if (out_cov_value !== e.cov || out_row_index !== e.row ||
            out_col_index !== e.col || out_divide_error !== e.div_err ||
            out_last_entry !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp cov %0d r %0d c %0d err %0d last %0d, got %0d %0d %0d %0d %0d",
                     e.cov, e.row, e.col, e.div_err, e.last, out_cov_value,
                     out_row_index, out_col_index, out_divide_error, out_last_entry);
        end
      end
    end
  end

  task automatic wait_idle();
    while (sample_queue.size() > 0 || in_valid || cov_expected.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_SAMPLE_COUNT: begin m_samples = data; m_load = 0; end
      REG_FEATURE_COUNT: begin m_features = data[3:0]; m_load = 0; end
      REG_NORMALIZE: m_norm = data[0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [8:0] ns, logic [8:0] nf, bit norm);
    wait_idle();
    write_reg(REG_SAMPLE_COUNT, ns);
    write_reg(REG_FEATURE_COUNT, nf);
    write_reg(REG_NORMALIZE, {8'd0, norm});
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(3))
      0: return 16'(int'($urandom_range(511)) - 256);
      1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic push_samples(int n, int mode);
    for (int k = 0; k < n; k++) begin
      case (mode)
        1: sample_queue.push_back(16'sh7fff);
        2: sample_queue.push_back(16'sh8000);
        3: sample_queue.push_back(k[0] ? 16'sh7fff : 16'sh8000);
        default: sample_queue.push_back(pick_sample());
      endcase
      item_total++;
    end
  endtask

  initial begin
    int ns;
    int nf;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset shape: two samples, one feature
    push_samples(2, 3);
    configure(9'd3, 9'd2, 1'b0);
    push_samples(6, 1);
    push_samples(6, 2);
    configure(9'd1, 9'd15, 1'b0);
    push_samples(8, 0);
    configure(9'd1, 9'd0, 1'b1);
    push_samples(1, 0);
    configure(9'd0, 9'd3, 1'b1);
    push_samples(3, 3);
    configure(9'd4, 9'd2, 1'b0);
    push_samples(5, 0);
    wait_idle();
    write_reg(REG_SAMPLE_COUNT, 9'd2);
    push_samples(4, 0);
    wait_idle();
    write_reg(REG_UNUSED, 9'h1ff);
    write_reg(REG_NORMALIZE, 9'd1);
    push_samples(4, 3);
    configure(9'd300, 9'd1, 1'b1);
    // long stretch with no idling on either side
    calm = 1'b1;
    push_samples(256, 0);
    configure(9'd2, 9'd8, 1'b0);
    calm = 1'b0;
    push_samples(16, 0);

    while (item_total < 340) begin
      ns = ($urandom_range(9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      nf = ($urandom_range(9) < 8) ? $urandom_range(1, 8) : $urandom_range(0, 15);
      configure(ns[8:0], nf[8:0], 1'($urandom_range(1)));
      if ($urandom_range(9) < 2) begin
        push_samples($urandom_range(1, 6), 0);
        wait_idle();
        if ($urandom_range(1)) write_reg(REG_SAMPLE_COUNT, ns[8:0]);
        else write_reg(REG_FEATURE_COUNT, nf[8:0]);
      end
      if ($urandom_range(9) == 0) write_reg(REG_UNUSED, 9'($urandom()));
      ns = eff_samples();
      nf = eff_features();
      repeat ($urandom_range(1, 2)) push_samples(ns * nf, 0);
    end

    wait_idle();
    calm = 1'b0;
    repeat (100) @(posedge clk);
    if (mismatches == 0 && cov_expected.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
